[design/aesbc_pkg.sv]
// Package for the AES block cipher unit: widths, register indexes, S-boxes
// and the GF(2^8) column mixing functions. No dependencies.
package aesbc_pkg;

    localparam int SCHEDULE_WORDS = 60;
    localparam int RK_ADDR_W      = $clog2(SCHEDULE_WORDS);
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_D = 3'd4;

    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;

    localparam logic [7:0] GF_POLY = 8'h1b;

    // Controller to datapath commands.
    typedef struct packed {
        logic                 load_block;   // capture input block, set direction
        logic                 key_init;     // copy one key word into schedule
        logic                 key_expand;   // derive one schedule word
        logic                 rk_read;      // issue round key word read
        logic [RK_ADDR_W-1:0] rk_addr;
        logic [1:0]           rk_col;       // column captured from last read
        logic                 rk_capture;   // latch read data into column
        logic                 round_first;  // initial AddRoundKey
        logic                 round_mid;    // full round
        logic                 round_last;   // final round
        logic                 out_load;     // move state into output register
    } aesbc_cmd_t;

    typedef struct packed {
        logic encrypt;
    } aesbc_stat_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Forward MixColumns on one column, byte 0 in the top byte.
    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                   a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                   a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                   xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // Inverse MixColumns as a pre-multiply by {04,05} followed by forward mix.
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] u, v;
        u = xtime(xtime(c[31:24] ^ c[15:8]));
        v = xtime(xtime(c[23:16] ^ c[7:0]));
        inv_mix_col = mix_col({c[31:24] ^ u, c[23:16] ^ v, c[15:8] ^ u, c[7:0] ^ v});
    endfunction

endpackage

[design/aesbc_if.sv]
// Valid/ready channel interfaces for the AES block cipher unit.
// No dependencies.
interface aesbc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    modport source (output valid, req_type, block_hi, block_lo, input ready);
    modport sink   (input valid, req_type, block_hi, block_lo, output ready);
endinterface

interface aesbc_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    modport source (output valid, result_hi, result_lo, input ready);
    modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

interface aesbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/aesbc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module aesbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[design/aesbc_datapath.sv]
// AES datapath: block state, round function, schedule expansion and store.
// Depends on aesbc_pkg and aesbc_ram.
module aesbc_datapath (
    input  logic                    clk,
    input  aesbc_pkg::aesbc_cmd_t   cmd,
    output aesbc_pkg::aesbc_stat_t  stat,
    input  logic                    req_type,
    input  logic [63:0]             block_hi,
    input  logic [63:0]             block_lo,
    input  logic [1:0]              key_length,
    input  logic [63:0]             key_word_a,
    input  logic [63:0]             key_word_b,
    input  logic [63:0]             key_word_c,
    input  logic [63:0]             key_word_d,
    output logic [127:0]            result
);
    import aesbc_pkg::*;

    logic [127:0]          state_reg;
    logic                  enc_reg;
    logic [31:0]           rk_reg [4];
    logic [31:0]           ram_rdata;
    logic [127:0]          rkey;
    logic [127:0]          result_reg;

    // Schedule expansion: window of the last 8 words, written to RAM as made.
    logic [31:0]           win_reg [8];
    logic [RK_ADDR_W-1:0]  widx_reg;
    logic [2:0]            kpos_reg;     // i mod nk
    logic [7:0]            rcon_reg;
    logic [3:0]            nk;
    logic [31:0]           key_w;
    logic [31:0]           t_word;
    logic [31:0]           new_word;
    logic                  ram_we;

    always_comb
    begin
        unique case (key_length)
            KLEN_128: nk = 4'd4;
            KLEN_192: nk = 4'd6;
            default:  nk = 4'd8;
        endcase
    end

    always_comb
    begin
        unique case (widx_reg[2:0])
            3'd0: key_w = key_word_a[63:32];
            3'd1: key_w = key_word_a[31:0];
            3'd2: key_w = key_word_b[63:32];
            3'd3: key_w = key_word_b[31:0];
            3'd4: key_w = key_word_c[63:32];
            3'd5: key_w = key_word_c[31:0];
            3'd6: key_w = key_word_d[63:32];
            default: key_w = key_word_d[31:0];
        endcase
    end

    // win_reg[0] is w[i-1]; w[i-nk] is win_reg[nk-1].
    always_comb
    begin
        t_word = win_reg[0];
        if (kpos_reg == 3'd0)
        begin
            t_word = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rcon_reg, 24'h0};
        end
        else if (nk == 4'd8 && kpos_reg == 3'd4)
        begin
            t_word = sub_word(win_reg[0]);
        end
        new_word = win_reg[3'(nk - 4'd1)] ^ t_word;
    end

    assign ram_we = cmd.key_init || cmd.key_expand;

    always_ff @(posedge clk)
    begin
        if (cmd.key_init || cmd.key_expand)
        begin
            for (int k = 7; k > 0; k--)
            begin
                win_reg[k] <= win_reg[k-1];
            end
            win_reg[0] <= cmd.key_init ? key_w : new_word;
            widx_reg   <= widx_reg + RK_ADDR_W'(1);
            if (cmd.key_expand)
            begin
                if (kpos_reg == 3'd0)
                begin
                    rcon_reg <= xtime(rcon_reg);
                end
                kpos_reg <= (kpos_reg == 3'(nk - 4'd1)) ? 3'd0 : kpos_reg + 3'd1;
            end
            else
            begin
                kpos_reg <= 3'd0;   // next expansion index is nk, a multiple of nk
            end
        end
        else if (cmd.load_block)
        begin
            widx_reg <= '0;
            rcon_reg <= 8'h01;
            kpos_reg <= 3'd0;
        end
    end

    aesbc_ram #(.WIDTH(32), .DEPTH(SCHEDULE_WORDS)) u_rk_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx_reg),
        .wdata (cmd.key_init ? key_w : new_word),
        .re    (cmd.rk_read),
        .raddr (cmd.rk_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.rk_capture)
        begin
            rk_reg[cmd.rk_col] <= ram_rdata;
        end
    end

    assign rkey = {rk_reg[0], rk_reg[1], rk_reg[2], rk_reg[3]};

    // Round function on a 128-bit state, byte 0 at the top, column-major.
    logic [127:0] sb_f, sr_f, mc_f, sr_i, sb_i, ak, mc_i, round_out;

    always_comb
    begin
        for (int b = 0; b < 16; b++)
        begin
            sb_f[127-8*b -: 8] = SBOX[state_reg[127-8*b -: 8]];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sr_f[127-8*(4*c+r) -: 8] = sb_f[127-8*(4*((c+r)%4)+r) -: 8];
                sr_i[127-8*(4*c+r) -: 8] = state_reg[127-8*(4*((c+4-r)%4)+r) -: 8];
            end
        end
        for (int b = 0; b < 16; b++)
        begin
            sb_i[127-8*b -: 8] = INV_SBOX[sr_i[127-8*b -: 8]];
        end
        for (int c = 0; c < 4; c++)
        begin
            mc_f[127-32*c -: 32] = mix_col(sr_f[127-32*c -: 32]);
        end
        ak = sb_i ^ rkey;
        for (int c = 0; c < 4; c++)
        begin
            mc_i[127-32*c -: 32] = inv_mix_col(ak[127-32*c -: 32]);
        end
        if (enc_reg)
        begin
            round_out = cmd.round_last ? (sr_f ^ rkey) : (mc_f ^ rkey);
        end
        else
        begin
            round_out = cmd.round_last ? ak : mc_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_block)
        begin
            state_reg <= {block_hi, block_lo};
            enc_reg   <= req_type;
        end
        else if (cmd.round_first)
        begin
            state_reg <= state_reg ^ rkey;
        end
        else if (cmd.round_mid || cmd.round_last)
        begin
            state_reg <= round_out;
        end
        if (cmd.out_load)
        begin
            result_reg <= state_reg;
        end
    end

    assign stat.encrypt = enc_reg;
    assign result       = result_reg;
endmodule

[design/aesbc_ctrl.sv]
// AES controller: schedules key expansion, round key reads and rounds.
// Depends on aesbc_pkg.
module aesbc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  logic [1:0]              key_length,
    input  aesbc_pkg::aesbc_stat_t  stat,
    output aesbc_pkg::aesbc_cmd_t   cmd
);
    import aesbc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_INIT,
        ST_KEY_EXP,
        ST_RK_FETCH,
        ST_ROUND,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [RK_ADDR_W-1:0] cnt_reg, cnt_next;      // schedule word or fetch index
    logic [3:0]           round_reg, round_next;  // rounds done so far
    logic                 out_valid_reg, out_valid_next;
    logic [3:0]           nk, nr;
    logic [RK_ADDR_W-1:0] total;
    logic [3:0]           rk_round;
    logic                 accept;

    always_comb
    begin
        unique case (key_length)
            KLEN_128: nk = 4'd4;
            KLEN_192: nk = 4'd6;
            default:  nk = 4'd8;
        endcase
        nr    = nk + 4'd6;
        total = RK_ADDR_W'({nr + 4'd1, 2'b00});
    end

    // Round key index: encryption walks up, decryption walks down.
    assign rk_round = stat.encrypt ? round_reg : (nr - round_reg);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.rk_addr    = RK_ADDR_W'({rk_round, 2'b00}) + cnt_reg;
        cmd.rk_col     = 2'(cnt_reg - RK_ADDR_W'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_block = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_KEY_INIT;
                end
            end
            ST_KEY_INIT:
            begin
                cmd.key_init = 1'b1;
                cnt_next     = cnt_reg + RK_ADDR_W'(1);
                if (cnt_reg == RK_ADDR_W'(nk - 4'd1))
                begin
                    state_next = ST_KEY_EXP;
                end
            end
            ST_KEY_EXP:
            begin
                cmd.key_expand = 1'b1;
                cnt_next       = cnt_reg + RK_ADDR_W'(1);
                if (cnt_reg == total - RK_ADDR_W'(1))
                begin
                    cnt_next   = '0;
                    round_next = '0;
                    state_next = ST_RK_FETCH;
                end
            end
            ST_RK_FETCH:
            begin
                // read words 0..3 of the round key, capture each in the next cycle
                cmd.rk_read    = (cnt_reg < RK_ADDR_W'(4));
                cmd.rk_capture = (cnt_reg != '0);
                cnt_next       = cnt_reg + RK_ADDR_W'(1);
                if (cnt_reg == RK_ADDR_W'(4))
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cnt_next = '0;
                if (round_reg == 4'd0)
                begin
                    cmd.round_first = 1'b1;
                end
                else if (round_reg == nr)
                begin
                    cmd.round_last = 1'b1;
                end
                else
                begin
                    cmd.round_mid = 1'b1;
                end
                if (round_reg == nr)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    round_next = round_reg + 4'd1;
                    state_next = ST_RK_FETCH;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_valid_reg && out_ready && !cmd.out_load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

[design/aes_block_cipher_unit.sv]
// Top level of the AES-128/192/256 ECB block cipher unit.
// Depends on aesbc_pkg, aesbc_if, aesbc_ctrl, aesbc_datapath, aesbc_ram.
//
//   channel  modport  fields                          transaction when
//   req      sink     req_type, block_hi, block_lo    req.valid & req.ready
//   rsp      source   result_hi, result_lo            rsp.valid & rsp.ready
//   cfg      sink     index (3b), data (64b)          cfg.valid & cfg.ready
//
// Per block: the Nk key words are loaded, the schedule is expanded to 4*(Nr+1)
// words, then Nr+1 round steps each fetch a round key through the single RAM
// read port and then apply the round; accept and hand-off bracket the block.
// Reset clears control and the key registers; the schedule RAM is not
// cleared, it is always rewritten before use. A finished result waits in
// the output register while the next request is taken; cfg is always ready.
module aes_block_cipher_unit (
    input logic       clk,
    input logic       rst_n,
    aesbc_req_if.sink   req,
    aesbc_rsp_if.source rsp,
    aesbc_cfg_if.sink   cfg
);
    import aesbc_pkg::*;

    logic [1:0]   key_length_reg;
    logic [63:0]  key_word_a_reg, key_word_b_reg, key_word_c_reg, key_word_d_reg;
    aesbc_cmd_t   cmd;
    aesbc_stat_t  stat;
    logic [127:0] result;

    assign cfg.ready = 1'b1;

    // Configuration registers; an unknown index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= '0;
            key_word_a_reg <= '0;
            key_word_b_reg <= '0;
            key_word_c_reg <= '0;
            key_word_d_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_KEY_LENGTH: key_length_reg <= cfg.data[1:0];
                REG_KEY_WORD_A: key_word_a_reg <= cfg.data;
                REG_KEY_WORD_B: key_word_b_reg <= cfg.data;
                REG_KEY_WORD_C: key_word_c_reg <= cfg.data;
                REG_KEY_WORD_D: key_word_d_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    aesbc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .key_length (key_length_reg),
        .stat       (stat),
        .cmd        (cmd)
    );

    aesbc_datapath u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (req.req_type),
        .block_hi   (req.block_hi),
        .block_lo   (req.block_lo),
        .key_length (key_length_reg),
        .key_word_a (key_word_a_reg),
        .key_word_b (key_word_b_reg),
        .key_word_c (key_word_c_reg),
        .key_word_d (key_word_d_reg),
        .result     (result)
    );

    assign rsp.result_hi = result[127:64];
    assign rsp.result_lo = result[63:0];

`ifndef ASSERT_OFF
    // Result register never overwritten while a result waits unaccepted.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp.valid || rsp.ready))
        else $error("result overwritten while pending");

    // Key expansion and rounds never overlap.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.key_init, cmd.key_expand, cmd.round_first,
                    cmd.round_mid, cmd.round_last}) <= 1)
        else $error("datapath commands overlap");

    // A request is only taken with no block in flight.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while busy");
`endif
endmodule
